/* rtl/lru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, the memory entry layout and the result record.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_W     = 10;
    localparam int MAX_FRAMES = 64;
    localparam int CFG_W      = 7;
    localparam int HIT_W      = 32;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // Entry of the forward-link memory: resident flag above the next pointer.
    typedef struct packed {
        logic              resident;
        logic [PAGE_W-1:0] link;
    } link_entry_t;

    // Result record; packs straight into the output tdata, hit in bit 0.
    typedef struct packed {
        logic [OUT_DATA_W-HIT_W-PAGE_W-3:0] pad;
        logic [HIT_W-1:0]                   hit_count;
        logic [PAGE_W-1:0]                  evicted_page;
        logic                               evicted_valid;
        logic                               hit;
    } result_t;

endpackage : lru_pkg
`default_nettype wire

/* rtl/lru_page_replacement_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement
// Tracks resident pages as a doubly linked list in two page-indexed memories.
// ----------------------------------------------------------------------------
// Sequence: a hit on the most recent page goes straight from lookup to result;
//   other hits unlink, then append; misses evict the head when full, then append.
// Throughput: one item at a time, since input is taken only in the idle state;
//   an item marked last adds a walk that clears the flag of every resident page.
// Reset: rst_n clears control state, frames_in_use returns to 64, then a
//   clearing pass over all 1024 entries wipes the resident flags before any input.
module lru_page_replacement_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration: frames_in_use
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lru_pkg::CFG_W-1:0]      cfg_data,
    // page references
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [lru_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] page, rest zero
    input  wire logic                           s_axis_tlast,  // last_of_run
    // results
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [lru_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [0] hit, [1] evicted_valid,
                                                               // [11:2] evicted_page,
                                                               // [43:12] hit_count, rest zero
    output logic                                m_axis_tlast   // run_done
);
    import lru_pkg::*;

    localparam int CNT_W = PAGE_W + 1;

    typedef enum logic [3:0] {
        S_INIT,     // clearing pass after reset
        S_IDLE,     // wait for a page reference
        S_LOOK,     // link data of the page and the head arrive
        S_UNLINK,   // hit: pull the page out of the list
        S_EVICT,    // full: drop the least recent page
        S_SETP,     // miss: mark the new page resident
        S_APPEND,   // link the page in as most recent
        S_DONE,     // hand the result to the output register
        S_WREAD,    // end of run: read the next list entry
        S_WCLR      // end of run: clear its resident flag
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   frames_in_use_reg;
    logic [PAGE_W-1:0]  page_reg;      // item page; list cursor during the walk
    logic               last_reg;
    logic [PAGE_W-1:0]  head_reg;      // least recent page
    logic [PAGE_W-1:0]  tail_reg;      // most recent page
    logic [CFG_W-1:0]   filled_reg;
    logic [HIT_W-1:0]   hits_reg;
    logic               empty_reg;     // append goes into an empty list
    logic [CNT_W-1:0]   cnt_reg;
    logic               hit_reg;
    logic               ev_valid_reg;
    logic [PAGE_W-1:0]  ev_page_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               out_last_reg;

    // Link memories
    link_entry_t        next_mem [PAGE_COUNT];
    logic [PAGE_W-1:0]  prev_mem [PAGE_COUNT];
    link_entry_t        nm_rd_p;       // entry of the page or the walk cursor
    link_entry_t        nm_rd_h;       // entry of the head
    logic [PAGE_W-1:0]  pm_rd_p;       // prev pointer of the page

    logic               in_accept;
    logic               nm_rd_en;
    logic [PAGE_W-1:0]  nm_raddr;
    logic               nm_we;
    logic [PAGE_W-1:0]  nm_waddr;
    link_entry_t        nm_wdata;
    logic               pm_we;
    logic [PAGE_W-1:0]  pm_waddr;
    logic [PAGE_W-1:0]  pm_wdata;
    logic [CFG_W-1:0]   limit;
    logic               out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Clamp the frame count to 1..MAX_FRAMES
    always_comb
    begin
        if (frames_in_use_reg == '0)
            limit = CFG_W'(1);
        else if (frames_in_use_reg > CFG_W'(MAX_FRAMES))
            limit = CFG_W'(MAX_FRAMES);
        else
            limit = frames_in_use_reg;
    end

    // Read ports: the page on accept, the cursor during the walk
    assign nm_rd_en = in_accept || (state_reg == S_WREAD);
    assign nm_raddr = in_accept ? s_axis_tdata[PAGE_W-1:0] : page_reg;

    // Write ports: one list edit per cycle
    always_comb
    begin
        nm_we    = 1'b0;
        nm_waddr = page_reg;
        nm_wdata = '{resident: 1'b1, link: '0};
        pm_we    = 1'b0;
        pm_waddr = page_reg;
        pm_wdata = tail_reg;
        case (state_reg)
            S_INIT:
            begin
                nm_we    = 1'b1;
                nm_waddr = cnt_reg[PAGE_W-1:0];
                nm_wdata = '{resident: 1'b0, link: '0};
            end
            S_UNLINK:
            begin
                // bridge prev -> next around the page
                nm_we    = (page_reg != head_reg);
                nm_waddr = pm_rd_p;
                nm_wdata = '{resident: 1'b1, link: nm_rd_p.link};
                pm_we    = 1'b1;
                pm_waddr = nm_rd_p.link;
                pm_wdata = pm_rd_p;
            end
            S_EVICT:
            begin
                nm_we    = 1'b1;
                nm_waddr = head_reg;
                nm_wdata = '{resident: 1'b0, link: '0};
            end
            S_SETP:
            begin
                nm_we = 1'b1;
            end
            S_APPEND:
            begin
                nm_we    = !empty_reg;
                nm_waddr = tail_reg;
                nm_wdata = '{resident: 1'b1, link: page_reg};
                pm_we    = !empty_reg;
            end
            S_WCLR:
            begin
                nm_we    = 1'b1;
                nm_wdata = '{resident: 1'b0, link: '0};
            end
            default:
            begin
                nm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
            next_mem[nm_waddr] <= nm_wdata;
        if (nm_rd_en)
            nm_rd_p <= next_mem[nm_raddr];
        if (in_accept)
            nm_rd_h <= next_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            prev_mem[pm_waddr] <= pm_wdata;
        if (in_accept)
            pm_rd_p <= prev_mem[s_axis_tdata[PAGE_W-1:0]];
    end

    // Sequencer with its registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_INIT;
            frames_in_use_reg <= CFG_W'(MAX_FRAMES);
            page_reg          <= '0;
            last_reg          <= 1'b0;
            head_reg          <= '0;
            tail_reg          <= '0;
            filled_reg        <= '0;
            hits_reg          <= '0;
            empty_reg         <= 1'b0;
            cnt_reg           <= '0;
            hit_reg           <= 1'b0;
            ev_valid_reg      <= 1'b0;
            ev_page_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frames_in_use_reg <= cfg_data;

            // raise valid as a result is loaded, drop it once its transaction completes
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_INIT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(PAGE_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        page_reg  <= s_axis_tdata[PAGE_W-1:0];
                        last_reg  <= s_axis_tlast;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_reg      <= nm_rd_p.resident;
                    ev_valid_reg <= 1'b0;
                    ev_page_reg  <= '0;
                    empty_reg    <= 1'b0;
                    if (nm_rd_p.resident)
                    begin
                        if (hits_reg != '1)
                            hits_reg <= hits_reg + HIT_W'(1);
                        // already most recent: nothing to move
                        state_reg <= (page_reg == tail_reg) ? S_DONE : S_UNLINK;
                    end
                    else if (filled_reg < limit)
                    begin
                        filled_reg <= filled_reg + CFG_W'(1);
                        empty_reg  <= (filled_reg == '0);
                        state_reg  <= S_SETP;
                    end
                    else
                    begin
                        ev_valid_reg <= 1'b1;
                        ev_page_reg  <= head_reg;
                        empty_reg    <= (filled_reg == CFG_W'(1));
                        state_reg    <= S_EVICT;
                    end
                end
                S_UNLINK:
                begin
                    if (page_reg == head_reg)
                        head_reg <= nm_rd_p.link;
                    state_reg <= S_APPEND;
                end
                S_EVICT:
                begin
                    head_reg  <= nm_rd_h.link;
                    state_reg <= S_SETP;
                end
                S_SETP:
                begin
                    state_reg <= S_APPEND;
                end
                S_APPEND:
                begin
                    if (empty_reg)
                        head_reg <= page_reg;
                    tail_reg  <= page_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_last_reg  <= last_reg;
                        out_data_reg  <= '{pad: '0, hit_count: hits_reg,
                                           evicted_page: ev_page_reg,
                                           evicted_valid: ev_valid_reg, hit: hit_reg};
                        if (last_reg)
                        begin
                            // walk the list from the head and drop every flag
                            page_reg  <= head_reg;
                            cnt_reg   <= CNT_W'(filled_reg);
                            state_reg <= S_WREAD;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_WREAD:
                begin
                    if (cnt_reg == '0)
                    begin
                        filled_reg <= '0;
                        hits_reg   <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                        state_reg <= S_WCLR;
                end
                S_WCLR:
                begin
                    page_reg  <= nm_rd_p.link;
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    state_reg <= S_WREAD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // The list never grows past the frame store
    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CFG_W'(MAX_FRAMES))
        else $error("resident page count above MAX_FRAMES");

    // An accepted reference always goes to the lookup step
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_LOOK)
        else $error("accepted reference skipped the lookup");

    // Eviction only happens from a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVICT) |-> filled_reg != '0)
        else $error("eviction with no resident page");

    // A miss never fills more frames than the limit allows
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && filled_reg < limit) |=> filled_reg <= limit)
        else $error("fill count passed the frame limit");
`endif

endmodule : lru_page_replacement_top
`default_nettype wire
